// ----- design/status_led_breathe_flash_macros.svh -----
// assertion macros for the status led block
// used by the checker module; no other dependencies
`ifndef STATUS_LED_BREATHE_FLASH_MACROS_SVH
`define STATUS_LED_BREATHE_FLASH_MACROS_SVH

// property checked outside reset
`define SLBF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("slbf check failed");

// property checked on every edge, reset included
`define SLBF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("slbf check failed");

`endif

// ----- design/slbf_pkg.sv -----
// shared types, codes and constants for the status led block
// no dependencies
package slbf_pkg;

  localparam int DUTY_BITS  = 8;
  localparam int STEP_SHIFT = DUTY_BITS - 3;
  localparam int TIME_BITS  = 12;
  localparam int IVAL_BITS  = 8;
  localparam int RS_BITS    = 4;
  localparam int UL_BITS    = 2;
  localparam int MODE_BITS  = 2;
  localparam int CLASS_BITS = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  typedef logic [DUTY_BITS-1:0]     duty_t;
  typedef logic [TIME_BITS-1:0]     time_t;
  typedef logic [IVAL_BITS-1:0]     ival_t;
  typedef logic [RS_BITS-1:0]       rs_t;
  typedef logic [UL_BITS-1:0]       ul_t;
  typedef logic [MODE_BITS-1:0]     mode_t;
  typedef logic [CLASS_BITS-1:0]    class_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  // run state classes
  localparam class_t CL_OFF     = 3'd0;
  localparam class_t CL_START   = 3'd1;
  localparam class_t CL_RUN     = 3'd2;
  localparam class_t CL_COOL    = 3'd3;
  localparam class_t CL_SUSPEND = 3'd4;
  localparam class_t CL_NONE    = 3'd7;

  // output modes
  localparam mode_t MODE_NONE   = 2'd0;
  localparam mode_t MODE_STATUS = 2'd1;
  localparam mode_t MODE_USER   = 2'd2;

  // register indexes
  localparam cfg_idx_t REG_OUTPUT_MODE      = 3'd0;
  localparam cfg_idx_t REG_PIN1_ENABLE      = 3'd1;
  localparam cfg_idx_t REG_PIN2_ENABLE      = 3'd2;
  localparam cfg_idx_t REG_BREATHE_INTERVAL = 3'd3;
  localparam cfg_idx_t REG_FLASH_ON_TIME    = 3'd4;
  localparam cfg_idx_t REG_FLASH_PERIOD     = 3'd5;

  // register reset values
  localparam ival_t BREATHE_RESET  = 8'd45;
  localparam time_t ON_TIME_RESET  = 12'd50;
  localparam time_t PERIOD_RESET   = 12'd2000;

  typedef struct packed {
    mode_t output_mode;
    logic  pin1_enable;
    logic  pin2_enable;
    ival_t breathe_interval;
    time_t flash_on_time;
    time_t flash_period;
  } cfg_t;

  typedef struct packed {
    class_t prev_class;
    duty_t  step_level;
    time_t  countdown;
    logic   pwm_on;
    logic   level_one;
    logic   level_two;
  } state_t;

  typedef struct packed {
    logic  pwm_enable;
    duty_t pwm_duty;
    logic  pin1_level;
    logic  pin2_level;
  } res_t;

  function automatic class_t classify(rs_t rs);
    class_t c;
    unique case (rs)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd9:    c = CL_START;
      4'd5:                            c = CL_RUN;
      4'd6, 4'd7, 4'd8, 4'd11, 4'd12:  c = CL_COOL;
      4'd10:                           c = CL_SUSPEND;
      default:                         c = CL_OFF;
    endcase
    return c;
  endfunction

endpackage

// ----- design/slbf_if.sv -----
// handshake channels for the status led block: tick in, result out, config write
// depends on slbf_pkg
interface slbf_tick_if;
  import slbf_pkg::*;
  logic valid;
  logic ready;
  rs_t  run_state;
  ul_t  user_levels;
  modport source (output valid, run_state, user_levels, input ready);
  modport sink (input valid, run_state, user_levels, output ready);
endinterface

interface slbf_result_if;
  import slbf_pkg::*;
  logic  valid;
  logic  ready;
  logic  pwm_enable;
  duty_t pwm_duty;
  logic  pin1_level;
  logic  pin2_level;
  modport source (output valid, pwm_enable, pwm_duty, pin1_level, pin2_level, input ready);
  modport sink (input valid, pwm_enable, pwm_duty, pin1_level, pin2_level, output ready);
endinterface

interface slbf_cfg_if;
  import slbf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/slbf_cfg.sv -----
// configuration register file of the status led block
// depends on slbf_pkg and slbf_cfg_if
module slbf_cfg (
  input  logic           clk,
  input  logic           rst,
  slbf_cfg_if.sink       cfg,
  output slbf_pkg::cfg_t regs,
  output logic           mode_wr
);
  import slbf_pkg::*;

  logic wr;

  // writes are always taken
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;
  assign mode_wr   = wr && (cfg.index == REG_OUTPUT_MODE);

  // register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.output_mode      <= MODE_NONE;
      regs.pin1_enable      <= 1'b0;
      regs.pin2_enable      <= 1'b0;
      regs.breathe_interval <= BREATHE_RESET;
      regs.flash_on_time    <= ON_TIME_RESET;
      regs.flash_period     <= PERIOD_RESET;
    end else if (wr) begin
      unique case (cfg.index)
        REG_OUTPUT_MODE:      regs.output_mode      <= cfg.data[MODE_BITS-1:0];
        REG_PIN1_ENABLE:      regs.pin1_enable      <= cfg.data[0];
        REG_PIN2_ENABLE:      regs.pin2_enable      <= cfg.data[0];
        REG_BREATHE_INTERVAL: regs.breathe_interval <= cfg.data[IVAL_BITS-1:0];
        REG_FLASH_ON_TIME:    regs.flash_on_time    <= cfg.data[TIME_BITS-1:0];
        REG_FLASH_PERIOD:     regs.flash_period     <= cfg.data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/slbf_tick.sv -----
// per-tick state update: countdown, class tracking, breathing and flash
// depends on slbf_pkg
module slbf_tick (
  input  logic           clk,
  input  logic           rst,
  input  slbf_pkg::cfg_t regs,
  input  logic           mode_wr,
  input  logic           step,
  input  slbf_pkg::rs_t  run_state,
  input  slbf_pkg::ul_t  user_levels,
  output slbf_pkg::res_t res_next
);
  import slbf_pkg::*;

  state_t st;
  state_t st_next;
  class_t cls;
  time_t  off_time;
  time_t  ival_ext;

  assign cls      = classify(run_state);
  assign off_time = (regs.flash_period > regs.flash_on_time) ?
                    regs.flash_period - regs.flash_on_time : '0;
  assign ival_ext = time_t'(regs.breathe_interval);

  // next state for one tick
  always_comb begin
    duty_t delta;
    st_next = st;
    delta   = '0;
    st_next.countdown = (st.countdown != '0) ? st.countdown - time_t'(1) : '0;
    unique case (regs.output_mode)
      MODE_STATUS: begin
        if (regs.pin1_enable) begin
          // class change restarts the pin
          if (cls != st.prev_class) begin
            st_next.prev_class = cls;
            st_next.step_level = '0;
            st_next.countdown  = ival_ext;
            unique case (cls)
              CL_START: st_next.pwm_on = 1'b1;
              CL_RUN: begin
                st_next.pwm_on    = 1'b0;
                st_next.level_one = 1'b1;
              end
              CL_COOL: begin
                st_next.pwm_on     = 1'b1;
                st_next.step_level = '1;
              end
              CL_SUSPEND: begin
                st_next.pwm_on    = 1'b0;
                st_next.level_one = 1'b0;
                st_next.countdown = off_time;
              end
              default: begin
                st_next.pwm_on    = 1'b0;
                st_next.level_one = 1'b0;
              end
            endcase
          end
          // timed event
          if (st_next.countdown == '0) begin
            if (cls == CL_START || cls == CL_COOL) begin
              delta = (st_next.step_level >> STEP_SHIFT) + duty_t'(1);
              st_next.step_level = (cls == CL_START) ? st_next.step_level + delta :
                                                       st_next.step_level - delta;
              st_next.countdown  = ival_ext;
            end else if (cls == CL_SUSPEND) begin
              st_next.step_level = st_next.step_level + duty_t'(1);
              if (st_next.step_level[0]) begin
                st_next.countdown = regs.flash_on_time;
                st_next.level_one = 1'b1;
              end else begin
                st_next.countdown = off_time;
                st_next.level_one = 1'b0;
              end
            end
          end
        end
      end
      MODE_USER: begin
        if (regs.pin1_enable) st_next.level_one = user_levels[0];
        if (regs.pin2_enable) st_next.level_two = user_levels[1];
      end
      default: ;
    endcase
  end

  // result fields follow the updated state
  assign res_next.pwm_enable = st_next.pwm_on;
  assign res_next.pwm_duty   = st_next.pwm_on ? st_next.step_level : '0;
  assign res_next.pin1_level = st_next.level_one;
  assign res_next.pin2_level = st_next.level_two;

  // state registers; a mode write forgets the class and stops the pwm
  always_ff @(posedge clk) begin
    if (rst) begin
      st.prev_class <= CL_NONE;
      st.step_level <= '0;
      st.countdown  <= '0;
      st.pwm_on     <= 1'b0;
      st.level_one  <= 1'b0;
      st.level_two  <= 1'b0;
    end else if (mode_wr) begin
      st.prev_class <= CL_NONE;
      st.pwm_on     <= 1'b0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

// ----- design/status_led_breathe_flash.sv -----
// Status LED driver. One tick beat in gives one result beat out. A tick is
// captured in an input register, the state update runs in one short pass of
// logic, and the result lands in an output register. One tick is taken every
// cycle as long as results are taken. The output register holds a stalled
// result while the input register keeps the next tick. Configuration writes
// are taken every cycle and are meant for when no beat is in flight; a write
// of output_mode also drops the current class and turns the pwm off. There is
// no clearing pass after reset.
// depends on slbf_pkg, slbf_if, slbf_cfg, slbf_tick
module status_led_breathe_flash (
  input  logic         clk,
  input  logic         rst,
  slbf_tick_if.sink    tick,
  slbf_result_if.source result,
  slbf_cfg_if.sink     cfg
);
  import slbf_pkg::*;

  cfg_t regs;
  logic mode_wr;
  logic in_valid;
  rs_t  in_rs;
  ul_t  in_ul;
  logic adv;
  logic step;
  res_t res_next;
  res_t res_q;
  logic out_valid;

  slbf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .regs    (regs),
    .mode_wr (mode_wr)
  );

  // output stage can move when empty or being taken
  assign adv        = !out_valid || result.ready;
  assign step       = adv && in_valid;
  assign tick.ready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_rs <= tick.run_state;
      in_ul <= tick.user_levels;
    end
  end

  slbf_tick u_tick (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .mode_wr     (mode_wr),
    .step        (step),
    .run_state   (in_rs),
    .user_levels (in_ul),
    .res_next    (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.pwm_enable = res_q.pwm_enable;
  assign result.pwm_duty   = res_q.pwm_duty;
  assign result.pin1_level = res_q.pin1_level;
  assign result.pin2_level = res_q.pin2_level;

endmodule

// ----- design/slbf_checker.sv -----
// port-level checks for the status led block, bound to the top level
// depends on slbf_pkg and status_led_breathe_flash_macros.svh
`include "status_led_breathe_flash_macros.svh"

module slbf_checker (
  input logic                clk,
  input logic                rst,
  input logic                tick_valid,
  input logic                tick_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic                pwm_enable,
  input slbf_pkg::duty_t     pwm_duty,
  input logic                pin1_level,
  input logic                pin2_level
);
  import slbf_pkg::*;

  // a stalled result keeps its fields
  `SLBF_ASSERT(a_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(pwm_enable) && $stable(pwm_duty) && $stable(pin1_level) && $stable(pin2_level))

  // duty reads zero whenever the pwm is off
  `SLBF_ASSERT(a_duty_off, clk, rst, result_valid && !pwm_enable |-> pwm_duty == '0)

  // reset empties the output
  `SLBF_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !result_valid)

  // a fresh result follows its tick beat through the input and result registers
  `SLBF_ASSERT(a_latency, clk, rst, $rose(result_valid) |-> $past(tick_valid && tick_ready, 2))

endmodule

bind status_led_breathe_flash slbf_checker u_slbf_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .pwm_enable   (result.pwm_enable),
  .pwm_duty     (result.pwm_duty),
  .pin1_level   (result.pin1_level),
  .pin2_level   (result.pin2_level)
);

// ----- dv/status_led_breathe_flash_tb.sv -----
`timescale 1ns / 100ps
// testbench for status_led_breathe_flash: directed and random tick beats,
// each result beat checked against an in-bench model of the led state
// depends on slbf_pkg, slbf_if and the status_led_breathe_flash rtl
module status_led_breathe_flash_tb;
  import slbf_pkg::*;

  localparam mode_t MODE_UNDEF    = 2'd3;
  localparam int    IDLE_PCT      = 9;
  localparam int    STALL_LIMIT   = 1000;
  localparam int    SETTLE_CYCLES = 4;
  localparam int    TICK_TARGET   = 1000;

  logic clk;
  logic rst;

  slbf_tick_if   tick_ch ();
  slbf_result_if led_ch ();
  slbf_cfg_if    cfg_ch ();

  status_led_breathe_flash u_dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (led_ch),
    .cfg    (cfg_ch)
  );

  // model copy of the registers and the led state
  cfg_t   led_cfg;
  state_t led_st;

  res_t pending_res[$];
  res_t want_res;
  int   errors;
  int   ticks_sent;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run state to class
  function automatic class_t run_class(rs_t rs);
    case (rs)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd9:   return CL_START;
      4'd5:                           return CL_RUN;
      4'd6, 4'd7, 4'd8, 4'd11, 4'd12: return CL_COOL;
      4'd10:                          return CL_SUSPEND;
      default:                        return CL_OFF;
    endcase
  endfunction

  // dark part of a suspend flash, zero when the period is not above on time
  function automatic time_t flash_off_time();
    if (led_cfg.flash_period > led_cfg.flash_on_time)
      return led_cfg.flash_period - led_cfg.flash_on_time;
    return '0;
  endfunction

  // one millisecond tick of the led logic, returns the expected result
  function automatic res_t advance_led(rs_t rs, ul_t ul);
    res_t   r;
    class_t cl;
    duty_t  delta;
    if (led_st.countdown != '0)
      led_st.countdown = led_st.countdown - time_t'(1);
    if (led_cfg.output_mode == MODE_STATUS) begin
      if (led_cfg.pin1_enable) begin
        cl = run_class(rs);
        // class change re-initialises the pin
        if (cl != led_st.prev_class) begin
          led_st.prev_class = cl;
          led_st.step_level = '0;
          led_st.countdown  = time_t'(led_cfg.breathe_interval);
          case (cl)
            CL_START: led_st.pwm_on = 1'b1;
            CL_RUN: begin
              led_st.pwm_on    = 1'b0;
              led_st.level_one = 1'b1;
            end
            CL_COOL: begin
              led_st.pwm_on     = 1'b1;
              led_st.step_level = '1;
            end
            CL_SUSPEND: begin
              led_st.pwm_on    = 1'b0;
              led_st.level_one = 1'b0;
              led_st.countdown = flash_off_time();
            end
            default: begin
              led_st.pwm_on    = 1'b0;
              led_st.level_one = 1'b0;
            end
          endcase
        end
        // timed events
        if (led_st.countdown == '0) begin
          if (cl == CL_START || cl == CL_COOL) begin
            delta = (led_st.step_level >> STEP_SHIFT) + duty_t'(1);
            if (cl == CL_START)
              led_st.step_level = led_st.step_level + delta;
            else
              led_st.step_level = led_st.step_level - delta;
            led_st.countdown = time_t'(led_cfg.breathe_interval);
          end else if (cl == CL_SUSPEND) begin
            led_st.step_level = led_st.step_level + duty_t'(1);
            if (led_st.step_level[0]) begin
              led_st.countdown = led_cfg.flash_on_time;
              led_st.level_one = 1'b1;
            end else begin
              led_st.countdown = flash_off_time();
              led_st.level_one = 1'b0;
            end
          end
        end
      end
    end else if (led_cfg.output_mode == MODE_USER) begin
      if (led_cfg.pin1_enable)
        led_st.level_one = ul[0];
      if (led_cfg.pin2_enable)
        led_st.level_two = ul[1];
    end
    r.pwm_enable = led_st.pwm_on;
    r.pwm_duty   = led_st.pwm_on ? led_st.step_level : '0;
    r.pin1_level = led_st.level_one;
    r.pin2_level = led_st.level_two;
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // result sink with random stalls
  initial begin
    led_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      led_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && led_ch.valid && led_ch.ready) begin
      if (pending_res.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want_res = pending_res.pop_front();
        if (led_ch.pwm_enable !== want_res.pwm_enable)
          report($sformatf("pwm_enable got %0b want %0b",
                           led_ch.pwm_enable, want_res.pwm_enable));
        if (led_ch.pwm_duty !== want_res.pwm_duty)
          report($sformatf("pwm_duty got %0d want %0d",
                           led_ch.pwm_duty, want_res.pwm_duty));
        if (led_ch.pin1_level !== want_res.pin1_level)
          report($sformatf("pin1_level got %0b want %0b",
                           led_ch.pin1_level, want_res.pin1_level));
        if (led_ch.pin2_level !== want_res.pin2_level)
          report($sformatf("pin2_level got %0b want %0b",
                           led_ch.pin2_level, want_res.pin2_level));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (led_ch.valid && led_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // register write, mirrored into the model when the beat is taken
  task automatic set_reg(cfg_idx_t idx, cfg_data_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_OUTPUT_MODE: begin
        led_cfg.output_mode = val[MODE_BITS-1:0];
        led_st.prev_class   = CL_NONE;
        led_st.pwm_on       = 1'b0;
      end
      REG_PIN1_ENABLE:      led_cfg.pin1_enable = val[0];
      REG_PIN2_ENABLE:      led_cfg.pin2_enable = val[0];
      REG_BREATHE_INTERVAL: led_cfg.breathe_interval = val[IVAL_BITS-1:0];
      REG_FLASH_ON_TIME:    led_cfg.flash_on_time = val[TIME_BITS-1:0];
      REG_FLASH_PERIOD:     led_cfg.flash_period = val[TIME_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one tick beat; valid stays high afterwards unless a gap follows
  task automatic send_tick(rs_t rs, ul_t ul);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.run_state   <= rs;
    tick_ch.user_levels <= ul;
    do @(posedge clk); while (!tick_ch.ready);
    pending_res.push_back(advance_led(rs, ul));
    ticks_sent++;
  endtask

  // stop sending and wait for every expected result
  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mode none after reset: outputs hold at zero
  task automatic test_reset_hold();
    send_tick(4'd1, 2'b11);
    send_tick(4'd15, 2'b01);
    settle();
  endtask

  // user mode, both pins and then pin two absent
  task automatic test_user_levels();
    set_reg(REG_OUTPUT_MODE, cfg_data_t'(MODE_USER));
    set_reg(REG_PIN1_ENABLE, cfg_data_t'(1));
    set_reg(REG_PIN2_ENABLE, cfg_data_t'(1));
    send_tick(4'd0, 2'b11);
    send_tick(4'd5, 2'b00);
    send_tick(4'd10, 2'b01);
    send_tick(4'd15, 2'b10);
    settle();
    set_reg(REG_PIN2_ENABLE, cfg_data_t'(0));
    send_tick(4'd0, 2'b01);
    settle();
  endtask

  // every class but suspend with a zero breathe interval so the duty steps each tick
  task automatic test_status_classes();
    set_reg(REG_OUTPUT_MODE, cfg_data_t'(MODE_STATUS));
    set_reg(REG_BREATHE_INTERVAL, cfg_data_t'(0));
    send_tick(4'd1, 2'b00);
    send_tick(4'd2, 2'b11);
    send_tick(4'd9, 2'b00);
    send_tick(4'd5, 2'b00);
    send_tick(4'd6, 2'b10);
    send_tick(4'd12, 2'b00);
    send_tick(4'd0, 2'b01);
    send_tick(4'd15, 2'b00);
    settle();
  endtask

  // suspend flash, then a period not above the on time
  task automatic test_suspend_flash();
    set_reg(REG_FLASH_ON_TIME, cfg_data_t'(1));
    set_reg(REG_FLASH_PERIOD, cfg_data_t'(2));
    repeat (4) send_tick(4'd10, 2'b00);
    settle();
    set_reg(REG_FLASH_ON_TIME, cfg_data_t'(4095));
    set_reg(REG_OUTPUT_MODE, cfg_data_t'(MODE_STATUS));
    repeat (2) send_tick(4'd10, 2'b11);
    settle();
  endtask

  // pin one absent in status mode, undefined mode
  task automatic test_odd_modes();
    set_reg(REG_PIN1_ENABLE, cfg_data_t'(0));
    send_tick(4'd5, 2'b00);
    settle();
    set_reg(REG_PIN1_ENABLE, cfg_data_t'(1));
    set_reg(REG_OUTPUT_MODE, cfg_data_t'(MODE_UNDEF));
    send_tick(4'd1, 2'b11);
    settle();
  endtask

  // mostly short timings, sometimes zero or the field maximum
  function automatic cfg_data_t pick_span(int top);
    case ($urandom_range(9))
      0:       return '0;
      1:       return cfg_data_t'(top);
      2:       return cfg_data_t'($urandom_range(top));
      default: return cfg_data_t'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic mode_t pick_mode();
    case ($urandom_range(9))
      0:             return MODE_NONE;
      1:             return MODE_UNDEF;
      2, 3, 4:       return MODE_USER;
      default:       return MODE_STATUS;
    endcase
  endfunction

  // phases of random settings with run states held for a while
  task automatic test_random_traffic();
    int   goal;
    int   phase;
    int   left;
    int   run_len;
    rs_t  rs;
    goal  = ticks_sent + TICK_TARGET;
    phase = 0;
    while (ticks_sent < goal) begin
      settle();
      quiet = (phase >= 6 && phase < 9);
      if (phase == 0 || $urandom_range(1))
        set_reg(REG_BREATHE_INTERVAL, pick_span(255));
      if (phase == 0 || $urandom_range(1))
        set_reg(REG_FLASH_ON_TIME, pick_span(4095));
      if (phase == 0 || $urandom_range(1))
        set_reg(REG_FLASH_PERIOD, pick_span(4095));
      if (phase == 0 || $urandom_range(1))
        set_reg(REG_PIN1_ENABLE, cfg_data_t'($urandom_range(9) != 0));
      if (phase == 0 || $urandom_range(1))
        set_reg(REG_PIN2_ENABLE, cfg_data_t'($urandom_range(1)));
      if (phase == 0 || $urandom_range(2) != 0)
        set_reg(REG_OUTPUT_MODE, cfg_data_t'(pick_mode()));
      left = $urandom_range(20, 80);
      while (left > 0) begin
        rs      = rs_t'($urandom_range(15));
        run_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 40);
        repeat (run_len) begin
          if (left > 0) begin
            send_tick(rs, ul_t'($urandom_range(3)));
            left--;
          end
        end
        // occasional drain in the middle of a phase
        if ($urandom_range(19) == 0)
          settle();
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  // stimulus
  initial begin
    rst                 = 1'b1;
    tick_ch.valid       = 1'b0;
    tick_ch.run_state   = '0;
    tick_ch.user_levels = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_OUTPUT_MODE;
    cfg_ch.data         = '0;
    errors              = 0;
    ticks_sent          = 0;
    led_cfg = '{MODE_NONE, 1'b0, 1'b0, BREATHE_RESET, ON_TIME_RESET, PERIOD_RESET};
    led_st  = '{CL_NONE, 8'd0, 12'd0, 1'b0, 1'b0, 1'b0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_hold();
    test_user_levels();
    test_status_classes();
    test_suspend_flash();
    test_odd_modes();
    test_random_traffic();
    settle();

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
